>>> rtl/bibd_pkg.sv
// ---------------------------------------------------------------------------
// bibd_pkg: shared types and constants for the inner boundary detector
// Field widths, configuration register indexes, and register clamp helpers.
// ---------------------------------------------------------------------------
package bibd_pkg;

  localparam int unsigned MaxWidth   = 1024;
  localparam int unsigned MaxHeight  = 4096;
  localparam int unsigned ColW       = $clog2(MaxWidth);
  localparam int unsigned RowW       = $clog2(MaxHeight);
  localparam int unsigned PixW       = 8;
  localparam int unsigned WidthRegW  = 11;
  localparam int unsigned HeightRegW = 13;
  localparam int unsigned CfgIdxW    = 1;
  localparam int unsigned CfgDataW   = 13;
  localparam int unsigned OutDataW   = ((ColW + RowW + 1 + 7) / 8) * 8;
  localparam int unsigned OutPadW    = OutDataW - (ColW + RowW + 1);
  localparam int unsigned FifoDepth  = 3;
  localparam int unsigned FifoPtrW   = $clog2(FifoDepth);
  localparam int unsigned FifoCntW   = $clog2(FifoDepth + 1);

  // reset values of the two size registers, kept as "minus one"
  localparam logic [ColW-1:0] WidthM1Reset  = ColW'(255);
  localparam logic [RowW-1:0] HeightM1Reset = RowW'(255);

  typedef enum logic [CfgIdxW-1:0] {
    RegImageWidth  = 1'b0,
    RegImageHeight = 1'b1
  } cfg_reg_e;

  // one result word
  typedef struct packed {
    logic            last;
    logic            bnd;
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
  } out_word_t;

  // pixel in flight between the issue stage and the window stage
  typedef struct packed {
    logic [ColW-1:0] addr;
    logic            pix;
    logic            emit;
    logic            last;
    logic [ColW-1:0] col;
    logic [RowW-1:0] row;
    logic            top;
    logic            bot;
    logic            left;
    logic            right;
  } stage_t;

  // width register -> width minus one, clamped to 1..MaxWidth
  function automatic logic [ColW-1:0] clamp_width_m1(input logic [WidthRegW-1:0] raw);
    logic [WidthRegW-1:0] dec;
    dec = raw - WidthRegW'(1);
    if (raw == '0) begin
      return '0;
    end else if (raw > WidthRegW'(MaxWidth)) begin
      return ColW'(MaxWidth - 1);
    end else begin
      return dec[ColW-1:0];
    end
  endfunction

  // height register -> height minus one, clamped to 1..MaxHeight
  function automatic logic [RowW-1:0] clamp_height_m1(input logic [HeightRegW-1:0] raw);
    logic [HeightRegW-1:0] dec;
    dec = raw - HeightRegW'(1);
    if (raw == '0) begin
      return '0;
    end else if (raw > HeightRegW'(MaxHeight)) begin
      return RowW'(MaxHeight - 1);
    end else begin
      return dec[RowW-1:0];
    end
  endfunction

endpackage

>>> rtl/binary_inner_boundary_detect_core.sv
// ---------------------------------------------------------------------------
// binary_inner_boundary_detect_core: 8-connected inner boundary of a label image
// Streams a raster label image and flags foreground pixels that touch background.
// ---------------------------------------------------------------------------
// Takes one pixel word per clock while its 3-deep output queue has room, and
// gives a result word per pixel in raster order; input flows while results wait.
// A pixel is foreground when its byte is nonzero; its result is a boundary when
// it is foreground and one of its 8 neighbors is background. Neighbors outside
// the frame count as foreground. Results trail the input by one row plus one
// pixel; after the last pixel of a frame, each flush word (tuser = 1) drains one
// result, and the final result carries tlast. Sustained rate is one word per
// clock unless stalled, set by the single line memory (2 bits x 1024: the row
// above and the row two above), read in the issue cycle and written back in the
// next, with a forward path for back-to-back hits on the same column (frames one
// pixel wide). A released result is registered in the window stage and the
// output queue. On a single-row frame the block takes one internal pad step
// right after the last pixel, during which tready is low for one cycle. Writing
// a size register abandons the frame in progress; write only when idle. The line
// memory needs no clearing: rows above the top of the frame are masked.
// ---------------------------------------------------------------------------
module binary_inner_boundary_detect_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [bibd_pkg::PixW-1:0]     s_axis_tdata,   // [7:0] pixel
  input  logic [0:0]                    s_axis_tuser,   // [0] cmd (1 = flush)
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [bibd_pkg::OutDataW-1:0] m_axis_tdata,   // [9:0] col, [21:10] row,
                                                        // [22] is_boundary, [23] zero
  output logic                          m_axis_tlast,
  // configuration writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bibd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [bibd_pkg::CfgDataW-1:0] cfg_data_i
);
  import bibd_pkg::*;

  // size registers, stored clamped as "minus one"
  logic [ColW-1:0] wm1_q, wm1_d;
  logic [RowW-1:0] hm1_q, hm1_d;

  // raster position of the next issued word and of the next result
  logic [ColW-1:0] in_col_q, in_col_d;
  logic [RowW-1:0] in_row_q, in_row_d;
  logic            done_q, done_d;    // all pixels of the frame taken
  logic            pad_q, pad_d;      // single-row frame: one internal step owed
  logic [ColW-1:0] out_col_q, out_col_d;
  logic [RowW-1:0] out_row_q, out_row_d;

  // issue stage
  logic cfg_acc, in_acc, cmd, real_px, flush, issue;
  logic col_wrap, row_end, emit, out_last;
  stage_t st_d;

  // window stage
  logic        s1_valid_q;
  stage_t      s1_q;
  logic [1:0]  line_mem [MaxWidth];   // [0] row above, [1] row two above
  logic [1:0]  rd_raw_q;
  logic        fwd_q;
  logic [1:0]  fwd_data_q;
  logic [1:0]  rdata, wdata;
  logic [2:0]  vec;                   // [2] top, [1] middle, [0] bottom row
  logic [2:0]  col_a_q, col_b_q;      // previous column, the one before
  logic [7:0]  nb_ok;
  logic        bnd;

  // output queue
  out_word_t              fifo_mem [FifoDepth];
  logic [FifoPtrW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [FifoCntW-1:0]    fifo_cnt_q;
  logic                   push, pop;
  out_word_t              push_word, head;

  // ---------------------------------------------------------------------
  // handshakes
  // ---------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i & cfg_ready_o;

  // room check counts the word in the window stage that will still push
  assign s_axis_tready = ~pad_q &
    (({1'b0, fifo_cnt_q} + (FifoCntW + 1)'(s1_valid_q & s1_q.emit))
      <= (FifoCntW + 1)'(FifoDepth - 1));

  assign in_acc  = s_axis_tvalid & s_axis_tready;
  assign cmd     = s_axis_tuser[0];
  // a pixel after the frame is complete, and a flush before, are dropped
  assign real_px = in_acc & ~done_q & ~cmd;
  assign flush   = in_acc & done_q & cmd;
  assign issue   = real_px | flush | pad_q;

  assign col_wrap = (in_col_q == wm1_q);
  assign row_end  = (in_row_q == hm1_q);
  assign out_last = (out_row_q == hm1_q) && (out_col_q == wm1_q);

  // results start once one row plus two pixels have gone in
  always_comb begin
    if (real_px) begin
      emit = (in_row_q > RowW'(1)) || ((in_row_q == RowW'(1)) && (in_col_q != '0));
    end else begin
      emit = flush;
    end
  end

  // ---------------------------------------------------------------------
  // issue stage: counters and edge masks
  // ---------------------------------------------------------------------
  always_comb begin
    wm1_d     = wm1_q;
    hm1_d     = hm1_q;
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    done_d    = done_q;
    pad_d     = pad_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;

    if (cfg_acc) begin
      unique case (cfg_reg_e'(cfg_index_i))
        RegImageWidth:  wm1_d = clamp_width_m1(cfg_data_i[WidthRegW-1:0]);
        RegImageHeight: hm1_d = clamp_height_m1(cfg_data_i[HeightRegW-1:0]);
        default:        ;
      endcase
      in_col_d  = '0;
      in_row_d  = '0;
      done_d    = 1'b0;
      pad_d     = 1'b0;
      out_col_d = '0;
      out_row_d = '0;
    end else if (issue) begin
      // flush and pad steps walk on along the row past the frame end
      in_col_d = col_wrap ? '0 : in_col_q + ColW'(1);
      pad_d    = real_px & col_wrap & row_end & (hm1_q == '0);
      if (real_px && col_wrap) begin
        if (row_end) begin
          done_d = 1'b1;
        end else begin
          in_row_d = in_row_q + RowW'(1);
        end
      end
      if (emit) begin
        if (out_last) begin
          in_col_d  = '0;
          in_row_d  = '0;
          done_d    = 1'b0;
          pad_d     = 1'b0;
          out_col_d = '0;
          out_row_d = '0;
        end else if (out_col_q == wm1_q) begin
          out_col_d = '0;
          out_row_d = out_row_q + RowW'(1);
        end else begin
          out_col_d = out_col_q + ColW'(1);
        end
      end
    end
  end

  always_comb begin
    st_d.addr  = in_col_q;
    st_d.pix   = real_px ? (|s_axis_tdata) : 1'b1;
    st_d.emit  = emit;
    st_d.last  = out_last;
    st_d.col   = out_col_q;
    st_d.row   = out_row_q;
    st_d.top   = (out_row_q == '0);
    st_d.bot   = (out_row_q == hm1_q);
    st_d.left  = (out_col_q == '0);
    st_d.right = (out_col_q == wm1_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wm1_q      <= WidthM1Reset;
      hm1_q      <= HeightM1Reset;
      in_col_q   <= '0;
      in_row_q   <= '0;
      done_q     <= 1'b0;
      pad_q      <= 1'b0;
      out_col_q  <= '0;
      out_row_q  <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      wm1_q      <= wm1_d;
      hm1_q      <= hm1_d;
      in_col_q   <= in_col_d;
      in_row_q   <= in_row_d;
      done_q     <= done_d;
      pad_q      <= pad_d;
      out_col_q  <= out_col_d;
      out_row_q  <= out_row_d;
      s1_valid_q <= issue & ~cfg_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_q <= st_d;
    end
  end

  // ---------------------------------------------------------------------
  // line memory: read at issue, write back in the window stage
  // ---------------------------------------------------------------------
  assign rdata = fwd_q ? fwd_data_q : rd_raw_q;
  assign wdata = {rdata[0], s1_q.pix};
  assign vec   = {rdata[1], rdata[0], s1_q.pix};

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      line_mem[s1_q.addr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      rd_raw_q <= line_mem[in_col_q];
    end
  end

  // same column twice in a row: the write above lands too late for the read
  always_ff @(posedge clk_i) begin
    if (issue) begin
      fwd_q      <= s1_valid_q && (s1_q.addr == in_col_q);
      fwd_data_q <= wdata;
    end
  end

  // ---------------------------------------------------------------------
  // 3x3 window: left = col_b, center = col_a, right = incoming column
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_a_q <= '1;
      col_b_q <= '1;
    end else if (s1_valid_q) begin
      col_b_q <= col_a_q;
      col_a_q <= vec;
    end
  end

  // neighbors off the frame read as foreground
  always_comb begin
    nb_ok[0] = col_b_q[2] | s1_q.top | s1_q.left;
    nb_ok[1] = col_b_q[1] | s1_q.left;
    nb_ok[2] = col_b_q[0] | s1_q.bot | s1_q.left;
    nb_ok[3] = col_a_q[2] | s1_q.top;
    nb_ok[4] = col_a_q[0] | s1_q.bot;
    nb_ok[5] = vec[2] | s1_q.top | s1_q.right;
    nb_ok[6] = vec[1] | s1_q.right;
    nb_ok[7] = vec[0] | s1_q.bot | s1_q.right;
    bnd      = col_a_q[1] & ~(&nb_ok);
  end

  // ---------------------------------------------------------------------
  // output queue
  // ---------------------------------------------------------------------
  assign push = s1_valid_q & s1_q.emit;
  assign pop  = m_axis_tvalid & m_axis_tready;

  always_comb begin
    push_word.last = s1_q.last;
    push_word.bnd  = bnd;
    push_word.row  = s1_q.row;
    push_word.col  = s1_q.col;
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_mem[wr_ptr_q] <= push_word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      fifo_cnt_q <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : wr_ptr_q + FifoPtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : rd_ptr_q + FifoPtrW'(1);
      end
      if (push && !pop) begin
        fifo_cnt_q <= fifo_cnt_q + FifoCntW'(1);
      end else if (pop && !push) begin
        fifo_cnt_q <= fifo_cnt_q - FifoCntW'(1);
      end
    end
  end

  assign head          = fifo_mem[rd_ptr_q];
  assign m_axis_tvalid = (fifo_cnt_q != '0);
  assign m_axis_tdata  = {{OutPadW{1'b0}}, head.bnd, head.row, head.col};
  assign m_axis_tlast  = head.last;

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
  // the input room check keeps the queue from overflowing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |-> (fifo_cnt_q < FifoCntW'(FifoDepth)))
    else $error("output queue overflow");

  // the pad step owns the issue slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pad_q |-> (!s_axis_tready && !in_acc))
    else $error("input taken during pad step");

  // the final result of a frame restarts every counter
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (issue && !cfg_acc && emit && out_last) |=>
      (in_col_q == '0 && in_row_q == '0 && !done_q && out_col_q == '0 && out_row_q == '0))
    else $error("counters not restarted after frame end");

endmodule

>>> sim/tb.sv
// ---------------------------------------------------------------------------
// tb: self-checking bench for binary_inner_boundary_detect_core
// Streams label frames of many sizes into the core and predicts every result
// word in the bench. The predictor keeps its own line store and counters and
// compares each result word, field by field, with what it expects.
// ---------------------------------------------------------------------------
module tb;
  import bibd_pkg::*;

  // input word kinds, carried on s_axis_tuser
  localparam logic CmdPixel = 1'b0;
  localparam logic CmdFlush = 1'b1;

  // cap for about 1.1k words at the worst gaps and stalls, several times over
  localparam int unsigned CycleLimit = 300_000;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [PixW-1:0]     s_axis_tdata;    // [7:0] pixel
  logic [0:0]          s_axis_tuser;    // [0] cmd
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;    // [9:0] col, [21:10] row, [22] is_boundary
  logic                m_axis_tlast;    // last result of the frame
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  binary_inner_boundary_detect_core u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Boundary predictor: mirror of the size registers, the line store (four row
  // slots of foreground bits, slot = row mod 4) and the in/out raster counters.
  // ---------------------------------------------------------------------------
  logic [WidthRegW-1:0]  width_reg  = WidthRegW'(256);
  logic [HeightRegW-1:0] height_reg = HeightRegW'(256);
  bit                    fg_rows [4][MaxWidth];
  int                    in_col, in_row, out_col, out_row;
  out_word_t             verdict_q [$];   // result words still owed by the core

  // run statistics
  int pixels_taken, words_ignored, results_seen, boundaries_seen, frames_drained;
  int mismatches;
  int unsigned cycle_cnt;

  // idling control: per-word gap of the sender, per-word stall of the receiver
  int tx_gap_max, rx_stall_max, rx_wait;

  function automatic int eff_width();
    if (width_reg == '0) return 1;
    if (width_reg > WidthRegW'(MaxWidth)) return MaxWidth;
    return int'(width_reg);
  endfunction

  function automatic int eff_height();
    if (height_reg == '0) return 1;
    if (height_reg > HeightRegW'(MaxHeight)) return MaxHeight;
    return int'(height_reg);
  endfunction

  function automatic bit frame_complete();
    return in_row >= eff_height();
  endfunction

  function automatic void restart_counts();
    in_col  = 0;
    in_row  = 0;
    out_col = 0;
    out_row = 0;
  endfunction

  // append one result word to the owed list
  function automatic void owe_result(out_word_t v);
    verdict_q = {verdict_q, v};
  endfunction

  // outside the frame reads as foreground
  function automatic bit fg_at(int r, int c, int w, int h);
    if (r < 0 || c < 0 || r >= h || c >= w) return 1'b1;
    return fg_rows[r & 3][c];
  endfunction

  // verdict for the next pixel in raster order, then step the out counters
  function automatic out_word_t next_verdict(int w, int h);
    out_word_t v;
    int dr, dc;
    v.col  = ColW'(out_col);
    v.row  = RowW'(out_row);
    v.bnd  = 1'b0;
    v.last = (out_row == h - 1) && (out_col == w - 1);
    if (fg_at(out_row, out_col, w, h)) begin
      for (dr = -1; dr <= 1; dr++) begin
        for (dc = -1; dc <= 1; dc++) begin
          if ((dr != 0 || dc != 0) && !fg_at(out_row + dr, out_col + dc, w, h)) begin
            v.bnd = 1'b1;
          end
        end
      end
    end
    if (v.last) begin
      restart_counts();
    end else if (out_col + 1 >= w) begin
      out_col = 0;
      out_row++;
    end else begin
      out_col++;
    end
    return v;
  endfunction

  // one accepted input word; queues the result word it releases, if any
  function automatic void track_input_word(logic cmd, logic [PixW-1:0] pix);
    int w, h;
    w = eff_width();
    h = eff_height();
    if (in_row >= h) begin
      // frame complete: only flush words drain, stray pixels are dropped
      if (cmd == CmdFlush) owe_result(next_verdict(w, h));
      else words_ignored++;
    end else if (cmd == CmdFlush) begin
      words_ignored++;  // flush while the frame is still arriving
    end else begin
      fg_rows[in_row & 3][in_col] = (pix != '0);
      pixels_taken++;
      if (in_col + 1 >= w) begin
        in_col = 0;
        in_row++;
      end else begin
        in_col++;
      end
      // a result is due once the pixel below-right of it has arrived
      if ((in_row * w + in_col) - (out_row * w + out_col) >= w + 2) begin
        owe_result(next_verdict(w, h));
      end
    end
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: every handshake is seen here at the rising edge. Inputs are
  // predicted before the output is checked, so a result can never overtake
  // the word that released it.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    out_word_t got, want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_reg_e'(cfg_index_i) == RegImageWidth) width_reg = cfg_data_i[WidthRegW-1:0];
        else height_reg = cfg_data_i[HeightRegW-1:0];
        restart_counts();  // any write abandons the frame
      end
      if (s_axis_tvalid && s_axis_tready) begin
        track_input_word(s_axis_tuser[0], s_axis_tdata);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = out_word_t'({m_axis_tlast, m_axis_tdata[ColW+RowW:0]});
        results_seen++;
        if (got.bnd) boundaries_seen++;
        if (got.last) frames_drained++;
        if (verdict_q.size() == 0) begin
          $error("result word with none expected: col %0d row %0d", got.col, got.row);
          mismatches++;
        end else begin
          want = verdict_q.pop_front();
          check_field("col", want.col, got.col);
          check_field("row", want.row, got.row);
          check_field("is_boundary", want.bnd, got.bnd);
          check_field("last", want.last, got.last);
        end
        rx_wait = $urandom_range(0, rx_stall_max);
      end
    end
  end

  // receiver: holds tready low for the drawn number of cycles after each word
  always @(negedge clk_i) begin
    if (rx_wait > 0) begin
      m_axis_tready <= 1'b0;
      rx_wait--;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CycleLimit) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers. All of them start and end at a falling edge. tvalid is only
  // lowered for a gap or a drain wait, so a back-to-back word keeps it high.
  // ---------------------------------------------------------------------------
  task automatic send_word(input logic cmd, input logic [PixW-1:0] pix);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid   <= 1'b1;
    s_axis_tuser[0] <= cmd;
    s_axis_tdata    <= pix;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // sender holds off until every owed result has come, plus the core latency
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  // leaves cfg_valid_i high; the caller lowers it after the last write
  task automatic write_reg(input cfg_reg_e idx, input logic [CfgDataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
  endtask

  task automatic set_frame_size(input logic [CfgDataW-1:0] w_data,
                                input logic [CfgDataW-1:0] h_data);
    wait_drained();
    write_reg(RegImageWidth, w_data);
    write_reg(RegImageHeight, h_data);
    cfg_valid_i <= 1'b0;
  endtask

  // One frame: fg_pct is the foreground share, hole forces one background
  // pixel (-1 none), keep >= 0 stops after that many pixels and leaves the
  // frame to be abandoned, noisy mixes in words the core must drop.
  task automatic run_frame(input logic [CfgDataW-1:0] w_data,
                           input logic [CfgDataW-1:0] h_data,
                           input int fg_pct, input int hole, input int keep,
                           input bit noisy);
    int npix, i;
    logic [PixW-1:0] pix;
    set_frame_size(w_data, h_data);
    npix = eff_width() * eff_height();
    if (keep >= 0 && keep < npix) npix = keep;
    for (i = 0; i < npix; i++) begin
      if (noisy && $urandom_range(0, 15) == 0) send_word(CmdFlush, PixW'($urandom));
      if ($urandom_range(0, 299) == 0) wait_drained();
      if (i == hole || $urandom_range(1, 100) > fg_pct) pix = '0;
      else pix = PixW'($urandom_range(1, 255));
      send_word(CmdPixel, pix);
    end
    if (keep < 0) begin
      while (frame_complete()) begin
        if (noisy && $urandom_range(0, 7) == 0) send_word(CmdPixel, PixW'($urandom));
        send_word(CmdFlush, PixW'($urandom));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // reset size is 256 x 256: run a little over one row, then abandon it
  task automatic test_reset_size();
    int i;
    tx_gap_max   = 3;
    rx_stall_max = 3;
    for (i = 0; i < 300; i++) begin
      send_word(CmdPixel, ($urandom_range(0, 4) == 0) ? '0 : PixW'($urandom_range(1, 255)));
    end
  endtask

  task automatic test_small_patterns();
    tx_gap_max   = 13;
    rx_stall_max = 13;
    run_frame(3, 3, 100, -1, -1, 1'b0);  // solid: nothing flagged
    run_frame(3, 3, 100, 4, -1, 1'b0);   // center hole: ring of eight
    run_frame(3, 3, 0, -1, -1, 1'b0);    // background never flags
    run_frame(1, 1, 100, -1, -1, 1'b0);  // lone pixel, all neighbors off frame
    // stray words on a 2 x 2 frame
    set_frame_size(2, 2);
    send_word(CmdFlush, 8'hFF);          // dropped: frame still arriving
    send_word(CmdPixel, 8'hFF);
    send_word(CmdPixel, 8'h01);
    send_word(CmdPixel, 8'h80);
    send_word(CmdPixel, 8'h00);
    send_word(CmdPixel, 8'h7F);          // dropped: frame already complete
    while (frame_complete()) send_word(CmdFlush, 8'h00);
  endtask

  task automatic test_size_extremes();
    tx_gap_max   = 13;
    rx_stall_max = 13;
    run_frame(0, 5, 70, -1, -1, 1'b1);        // width 0 runs as 1
    run_frame(13'h1805, 0, 70, -1, -1, 1'b1); // upper width bits dropped; one row
    tx_gap_max   = 2;
    rx_stall_max = 2;
    run_frame(1, 40, 90, -1, -1, 1'b0);       // one pixel wide, many rows
  endtask

  // a size write in mid frame must drop the partial frame
  task automatic test_abandon();
    tx_gap_max   = 13;
    rx_stall_max = 13;
    run_frame(8, 6, 80, -1, 20, 1'b0);
    run_frame(5, 4, 80, -1, 3, 1'b1);
    run_frame(5, 4, 80, -1, -1, 1'b1);
  endtask

  task automatic test_random_frames();
    int start, w, h, keep;
    start = pixels_taken;
    while (pixels_taken - start < 450) begin
      tx_gap_max   = $urandom_range(0, 1) ? 13 : 0;
      rx_stall_max = $urandom_range(0, 1) ? 13 : 0;
      w    = ($urandom_range(0, 4) == 0) ? $urandom_range(17, 64) : $urandom_range(0, 16);
      h    = $urandom_range(0, 9);
      keep = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : -1;
      run_frame({2'($urandom), 11'(w)}, 13'(h), 40 + 20 * $urandom_range(0, 3), -1, keep,
                $urandom_range(0, 2) == 0);
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = RegImageWidth;
    cfg_data_i    = '0;
    tx_gap_max    = 0;
    rx_stall_max  = 0;
    rx_wait       = 0;
    cycle_cnt     = 0;
    restart_counts();
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_size();
    test_small_patterns();
    test_size_extremes();
    test_abandon();
    test_random_frames();

    wait_drained();
    repeat (20) @(negedge clk_i);
    $display("run: %0d pixel words, %0d dropped words, %0d result words checked",
             pixels_taken, words_ignored, results_seen);
    $display("run: %0d boundary pixels flagged, %0d frames fully drained",
             boundaries_seen, frames_drained);
    if (mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/bibd_pkg.sv
rtl/binary_inner_boundary_detect_core.sv
sim/tb.sv
